>>> design/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg: shared constants and types for the correlation engine
// Widths of the running sums, big-number limb sizes and operation codes.
// ----------------------------------------------------------------------------
package pce_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int COUNT_BITS  = 16;

  localparam int CNT_W = COUNT_BITS + 1;
  localparam int N_W   = WEIGHT_BITS + COUNT_BITS + 1;
  localparam int XS_W  = SAMPLE_BITS + WEIGHT_BITS + COUNT_BITS + 1;
  localparam int SQ_W  = 64;

  // big-number operands: four 32-bit limbs, product of eight
  localparam int LIMB_W = 32;
  localparam int BN_W   = 4 * LIMB_W;
  localparam int MR_W   = 2 * BN_W;
  localparam int SR_W   = MR_W + 8;

  localparam logic [1:0] STAT_VALID = 2'd0;
  localparam logic [1:0] STAT_UNDEF = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;

  typedef enum logic [3:0] {
    OP_WX  = 4'd0,
    OP_WY  = 4'd1,
    OP_XX  = 4'd2,
    OP_WXX = 4'd3,
    OP_YY  = 4'd4,
    OP_WYY = 4'd5,
    OP_XY  = 4'd6,
    OP_WXY = 4'd7,
    OP_NXX = 4'd8,
    OP_SX  = 4'd9,
    OP_NYY = 4'd10,
    OP_SY  = 4'd11,
    OP_NXY = 4'd12,
    OP_SXY = 4'd13,
    OP_AB  = 4'd14,
    OP_CC  = 4'd15
  } op_t;

  // multiplier control: start pulse and index of the last limb of each operand
  typedef struct packed {
    logic       start;
    logic [1:0] a_last;
    logic [1:0] b_last;
  } mul_ctl_t;

endpackage

>>> design/pce_mul.sv
// ----------------------------------------------------------------------------
// pce_mul: limb-serial big-number multiplier
// One 32x32 product a cycle, registered, then added into a 256-bit sum.
// ----------------------------------------------------------------------------
module pce_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  pce_pkg::mul_ctl_t        ctl,
  input  logic [pce_pkg::BN_W-1:0] a,
  input  logic [pce_pkg::BN_W-1:0] b,
  output logic                     done,
  output logic [pce_pkg::MR_W-1:0] res
);

  localparam int LW = pce_pkg::LIMB_W;
  localparam int MW = pce_pkg::MR_W;

  logic          run;
  logic [1:0]    i;
  logic [1:0]    j;
  logic [1:0]    a_last;
  logic [1:0]    b_last;
  logic [2*LW-1:0] prod;
  logic [2:0]    psh;
  logic          pv;
  logic          plast;
  logic [MW-1:0] acc;
  logic [LW-1:0] a_limb;
  logic [LW-1:0] b_limb;

  assign a_limb = a[{i, 5'b0} +: LW];
  assign b_limb = b[{j, 5'b0} +: LW];
  assign res    = acc;

  always_ff @(posedge clk) begin
    prod  <= a_limb * b_limb;
    psh   <= 3'(i) + 3'(j);
    plast <= run && (i == a_last) && (j == b_last);
    if (ctl.start) begin
      acc    <= '0;
      a_last <= ctl.a_last;
      b_last <= ctl.b_last;
    end else if (pv) begin
      acc <= acc + ((MW'(prod)) << {psh, 5'b0});
    end
    if (rst) begin
      run  <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      i    <= '0;
      j    <= '0;
    end else begin
      done <= pv && plast;
      pv   <= run;
      if (ctl.start) begin
        run <= 1'b1;
        i   <= '0;
        j   <= '0;
      end else if (run) begin
        if (j == b_last) begin
          j <= '0;
          if (i == a_last) begin
            run <= 1'b0;
          end else begin
            i <= i + 2'd1;
          end
        end else begin
          j <= j + 2'd1;
        end
      end
    end
  end

endmodule

>>> design/pearson_correlation_engine.sv
// ----------------------------------------------------------------------------
// pearson_correlation_engine: weighted Pearson correlation over a stream
// Running weighted sums per word, exact Q2.30 coefficient on the last word.
// ----------------------------------------------------------------------------
// One shared limb-serial multiplier does all the arithmetic. A kept word
// needs eight single-limb products, plus the accept and check steps; a
// skipped word needs only those two steps. On a word with tlast the
// coefficient then takes six 2x2-limb products, two 4x4-limb products and
// a 31-step root search, then the output step. The input is not ready
// while a word is being worked on. The result waits in an output register
// until taken.
module pearson_correlation_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // weighted_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sample_x[15:0], sample_y[31:16], weight[47:32]
  input  logic        s_axis_tuser,   // skip
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // correlation[31:0]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int SB   = pce_pkg::SAMPLE_BITS;
  localparam int WB   = pce_pkg::WEIGHT_BITS;
  localparam int CB   = pce_pkg::COUNT_BITS;
  localparam int CW   = pce_pkg::CNT_W;
  localparam int NW   = pce_pkg::N_W;
  localparam int XW   = pce_pkg::XS_W;
  localparam int QW   = pce_pkg::SQ_W;
  localparam int BW   = pce_pkg::BN_W;
  localparam int MW   = pce_pkg::MR_W;
  localparam int SW   = pce_pkg::SR_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_ISSUE = 6'b000100,
    S_WAIT  = 6'b001000,
    S_SRCH  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t          state;
  pce_pkg::op_t    op;
  logic            weighted_mode;

  logic [SB-1:0]   ax;
  logic [SB-1:0]   ay;
  logic            sx;
  logic            sy;
  logic [WB-1:0]   w_eff;
  logic            last_flag;
  logic [2*SB-1:0] tmp;

  logic [CW-1:0]   item_count;
  logic [NW-1:0]   weight_sum;
  logic [XW-1:0]   x_sum;
  logic [XW-1:0]   y_sum;
  logic [QW-1:0]   xx_sum;
  logic [QW-1:0]   yy_sum;
  logic [QW-1:0]   xy_sum;
  logic            overflow_seen;

  logic [BW-1:0]   t1;
  logic [BW-1:0]   a_var;
  logic [BW-1:0]   b_var;
  logic [BW-1:0]   c_cov;
  logic            c_neg;

  logic [SW-1:0]   srch_p;
  logic [SW-1:0]   srch_q;
  logic [SW-1:0]   srch_ab;
  logic [SW-1:0]   srch_cc;
  logic [SW-1:0]   sum1;
  logic            half;
  logic [4:0]      bit_idx;
  logic [30:0]     root;

  logic [31:0]     res_corr;
  logic [1:0]      res_status;

  pce_pkg::mul_ctl_t mctl;
  logic [BW-1:0]   mul_a;
  logic [BW-1:0]   mul_b;
  logic            mul_done;
  logic [MW-1:0]   mres;

  logic [SB-1:0]   xr;
  logic [SB-1:0]   yr;
  logic [XW-1:0]   xs_mag;
  logic [XW-1:0]   ys_mag;
  logic [QW-1:0]   xy_mag;
  logic [NW-1:0]   n_val;
  logic [SW-1:0]   cand;
  logic            take;

  assign xr     = s_axis_tdata[SB-1:0];
  assign yr     = s_axis_tdata[16 +: SB];
  assign xs_mag = x_sum[XW-1] ? (~x_sum + XW'(1)) : x_sum;
  assign ys_mag = y_sum[XW-1] ? (~y_sum + XW'(1)) : y_sum;
  assign xy_mag = xy_sum[QW-1] ? (~xy_sum + QW'(1)) : xy_sum;
  assign n_val  = weighted_mode ? weight_sum : NW'(item_count);
  assign cand   = sum1 + srch_ab;
  assign take   = !root[30] && (cand <= srch_cc);

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    mctl.start  = (state == S_ISSUE);
    mctl.a_last = 2'd0;
    mctl.b_last = 2'd0;
    unique case (op)
      pce_pkg::OP_WX:  begin mul_a = BW'(w_eff); mul_b = BW'(ax);  end
      pce_pkg::OP_WY:  begin mul_a = BW'(w_eff); mul_b = BW'(ay);  end
      pce_pkg::OP_XX:  begin mul_a = BW'(ax);    mul_b = BW'(ax);  end
      pce_pkg::OP_YY:  begin mul_a = BW'(ay);    mul_b = BW'(ay);  end
      pce_pkg::OP_XY:  begin mul_a = BW'(ax);    mul_b = BW'(ay);  end
      pce_pkg::OP_WXX,
      pce_pkg::OP_WYY,
      pce_pkg::OP_WXY: begin mul_a = BW'(w_eff); mul_b = BW'(tmp); end
      pce_pkg::OP_NXX: begin
        mul_a = BW'(n_val); mul_b = BW'(xx_sum);
        mctl.a_last = 2'd1; mctl.b_last = 2'd1;
      end
      pce_pkg::OP_SX: begin
        mul_a = BW'(xs_mag); mul_b = BW'(xs_mag);
        mctl.a_last = 2'd1; mctl.b_last = 2'd1;
      end
      pce_pkg::OP_NYY: begin
        mul_a = BW'(n_val); mul_b = BW'(yy_sum);
        mctl.a_last = 2'd1; mctl.b_last = 2'd1;
      end
      pce_pkg::OP_SY: begin
        mul_a = BW'(ys_mag); mul_b = BW'(ys_mag);
        mctl.a_last = 2'd1; mctl.b_last = 2'd1;
      end
      pce_pkg::OP_NXY: begin
        mul_a = BW'(n_val); mul_b = BW'(xy_mag);
        mctl.a_last = 2'd1; mctl.b_last = 2'd1;
      end
      pce_pkg::OP_SXY: begin
        mul_a = BW'(xs_mag); mul_b = BW'(ys_mag);
        mctl.a_last = 2'd1; mctl.b_last = 2'd1;
      end
      pce_pkg::OP_AB: begin
        mul_a = a_var; mul_b = b_var;
        mctl.a_last = 2'd3; mctl.b_last = 2'd3;
      end
      pce_pkg::OP_CC: begin
        mul_a = c_cov; mul_b = c_cov;
        mctl.a_last = 2'd3; mctl.b_last = 2'd3;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  pce_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mctl),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op            <= pce_pkg::OP_WX;
      weighted_mode <= 1'b0;
      item_count    <= '0;
      weight_sum    <= '0;
      x_sum         <= '0;
      y_sum         <= '0;
      xx_sum        <= '0;
      yy_sum        <= '0;
      xy_sum        <= '0;
      overflow_seen <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        weighted_mode <= cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sx        <= xr[SB-1];
            sy        <= yr[SB-1];
            ax        <= xr[SB-1] ? (~xr + SB'(1)) : xr;
            ay        <= yr[SB-1] ? (~yr + SB'(1)) : yr;
            last_flag <= s_axis_tlast;
            state     <= S_CHECK;
            w_eff     <= weighted_mode ? s_axis_tdata[32 +: WB] : WB'(1);
            if (item_count[CB]) begin
              overflow_seen <= 1'b1;
            end else begin
              item_count <= item_count + CW'(1);
              if (!s_axis_tuser) begin
                weight_sum <= weight_sum +
                  (weighted_mode ? NW'(s_axis_tdata[32 +: WB]) : NW'(1));
                op    <= pce_pkg::OP_WX;
                state <= S_ISSUE;
              end
            end
          end
        end
        S_CHECK: begin
          res_corr <= '0;
          if (!last_flag) begin
            state <= S_IDLE;
          end else if (overflow_seen) begin
            res_status <= pce_pkg::STAT_OVF;
            state      <= S_OUT;
          end else if (n_val == '0) begin
            res_status <= pce_pkg::STAT_UNDEF;
            state      <= S_OUT;
          end else begin
            op    <= pce_pkg::OP_NXX;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            state <= S_ISSUE;
            unique case (op)
              pce_pkg::OP_WX: begin
                x_sum <= sx ? x_sum - XW'(mres[WB+SB-1:0]) : x_sum + XW'(mres[WB+SB-1:0]);
                op    <= pce_pkg::OP_WY;
              end
              pce_pkg::OP_WY: begin
                y_sum <= sy ? y_sum - XW'(mres[WB+SB-1:0]) : y_sum + XW'(mres[WB+SB-1:0]);
                op    <= pce_pkg::OP_XX;
              end
              pce_pkg::OP_XX: begin
                tmp <= mres[2*SB-1:0];
                op  <= pce_pkg::OP_WXX;
              end
              pce_pkg::OP_WXX: begin
                xx_sum <= xx_sum + mres[QW-1:0];
                op     <= pce_pkg::OP_YY;
              end
              pce_pkg::OP_YY: begin
                tmp <= mres[2*SB-1:0];
                op  <= pce_pkg::OP_WYY;
              end
              pce_pkg::OP_WYY: begin
                yy_sum <= yy_sum + mres[QW-1:0];
                op     <= pce_pkg::OP_XY;
              end
              pce_pkg::OP_XY: begin
                tmp <= mres[2*SB-1:0];
                op  <= pce_pkg::OP_WXY;
              end
              pce_pkg::OP_WXY: begin
                xy_sum <= (sx ^ sy) ? xy_sum - mres[QW-1:0] : xy_sum + mres[QW-1:0];
                state  <= S_CHECK;
              end
              pce_pkg::OP_NXX: begin
                t1 <= mres[BW-1:0];
                op <= pce_pkg::OP_SX;
              end
              pce_pkg::OP_SX: begin
                a_var <= t1 - mres[BW-1:0];
                op    <= pce_pkg::OP_NYY;
                if (t1 <= mres[BW-1:0]) begin
                  res_status <= pce_pkg::STAT_UNDEF;
                  state      <= S_OUT;
                end
              end
              pce_pkg::OP_NYY: begin
                t1 <= mres[BW-1:0];
                op <= pce_pkg::OP_SY;
              end
              pce_pkg::OP_SY: begin
                b_var <= t1 - mres[BW-1:0];
                op    <= pce_pkg::OP_NXY;
                if (t1 <= mres[BW-1:0]) begin
                  res_status <= pce_pkg::STAT_UNDEF;
                  state      <= S_OUT;
                end
              end
              pce_pkg::OP_NXY: begin
                t1 <= mres[BW-1:0];
                op <= pce_pkg::OP_SXY;
              end
              pce_pkg::OP_SXY: begin
                // covariance term: n*Sxy against Sx*Sy, signs held apart
                priority if (xy_sum[QW-1] != (x_sum[XW-1] ^ y_sum[XW-1])) begin
                  c_cov <= t1 + mres[BW-1:0];
                  c_neg <= xy_sum[QW-1];
                end else if (t1 >= mres[BW-1:0]) begin
                  c_cov <= t1 - mres[BW-1:0];
                  c_neg <= xy_sum[QW-1];
                end else begin
                  c_cov <= mres[BW-1:0] - t1;
                  c_neg <= !xy_sum[QW-1];
                end
                op <= pce_pkg::OP_AB;
              end
              pce_pkg::OP_AB: begin
                srch_ab <= {mres[SW-61:0], 60'b0};
                op      <= pce_pkg::OP_CC;
              end
              pce_pkg::OP_CC: begin
                srch_cc <= {mres[SW-61:0], 60'b0};
                srch_p  <= '0;
                srch_q  <= '0;
                root    <= '0;
                bit_idx <= 5'd30;
                half    <= 1'b0;
                state   <= S_SRCH;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SRCH: begin
          // p = AB*r^2, q = AB*r << (bit+1), ab = AB << 2*bit
          half <= !half;
          if (!half) begin
            sum1 <= srch_p + srch_q;
          end else begin
            srch_ab <= srch_ab >> 2;
            if (take) begin
              root[bit_idx] <= 1'b1;
              srch_p        <= cand;
              srch_q        <= (srch_q + (srch_ab << 1)) >> 1;
            end else begin
              srch_q <= srch_q >> 1;
            end
            if (bit_idx == 5'd0) begin
              state <= S_OUT;
            end else begin
              bit_idx <= bit_idx - 5'd1;
            end
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_corr;
            m_axis_tuser  <= res_status;
            item_count    <= '0;
            weight_sum    <= '0;
            x_sum         <= '0;
            y_sum         <= '0;
            xx_sum        <= '0;
            yy_sum        <= '0;
            xy_sum        <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // search finished this cycle: form the signed result
      if (state == S_SRCH && half && bit_idx == 5'd0) begin
        res_status <= pce_pkg::STAT_VALID;
        res_corr   <= c_neg ? (~32'({root[30:1], root[0] | take}) + 32'd1)
                            : 32'({root[30:1], root[0] | take});
      end
    end
  end

endmodule

>>> bench/pearson_correlation_engine_tb.sv
// ----------------------------------------------------------------------------
// pearson_correlation_engine_tb: self-checking bench for the correlation engine
// Streams sample words in plain and weighted mode, predicts each coefficient
// with exact wide integer arithmetic and compares every result word.
// ----------------------------------------------------------------------------
class corr_scoreboard;
  bit          weighted;
  logic [16:0] n_items;
  logic [32:0] w_total;
  logic signed [48:0] sx, sy;
  logic [63:0] sxx, syy;
  logic signed [63:0] sxy;
  bit          ovf;
  logic [31:0] exp_corr[$];
  logic [1:0]  exp_stat[$];
  int          errors;
  int          results;

  function void clear();
    n_items = 0; w_total = 0; sx = 0; sy = 0;
    sxx = 0; syy = 0; sxy = 0; ovf = 0;
  endfunction

  function automatic logic [255:0] mag(input logic signed [63:0] v);
    mag = (v < 0) ? 256'(-v) : 256'(v);
  endfunction

  // exact coefficient from the current sums; returns status
  function automatic logic [1:0] coefficient(output logic [31:0] corr);
    logic [255:0] n, a, b, t1, t2, p, q, c;
    logic [511:0] ab, cc, tt;
    logic [63:0]  r, t;
    bit ps, qs, cs;
    corr = 0;
    if (ovf) return pce_pkg::STAT_OVF;
    n = weighted ? 256'(w_total) : 256'(n_items);
    if (n == 0) return pce_pkg::STAT_UNDEF;
    t1 = n * 256'(sxx); t2 = mag(sx) * mag(sx);
    if (t1 <= t2) return pce_pkg::STAT_UNDEF;
    a = t1 - t2;
    t1 = n * 256'(syy); t2 = mag(sy) * mag(sy);
    if (t1 <= t2) return pce_pkg::STAT_UNDEF;
    b = t1 - t2;
    p = n * mag(sxy); ps = sxy < 0;
    q = mag(sx) * mag(sy); qs = (sx < 0) != (sy < 0);
    if (ps != qs) begin
      c = p + q; cs = ps;
    end else if (p >= q) begin
      c = p - q; cs = ps;
    end else begin
      c = q - p; cs = !ps;
    end
    ab = 512'(a) * 512'(b);
    cc = (512'(c) * 512'(c)) << 60;
    r = 0;
    for (int bit_i = 30; bit_i >= 0; bit_i--) begin
      t = r | (64'd1 << bit_i);
      if (t > (64'd1 << 30)) continue;
      tt = ab * 512'(t * t);
      if (tt <= cc) r = t;
    end
    corr = cs ? 32'(-r) : 32'(r);
    return pce_pkg::STAT_VALID;
  endfunction

  function void note_word(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic [15:0] w_in, input bit skip, input bit last);
    logic [63:0] w;
    logic signed [63:0] xs, ys;
    logic [31:0] corr;
    logic [1:0]  st;
    w = weighted ? 64'(w_in) : 64'd1;
    xs = x; ys = y;
    if (n_items >= 17'(1 << pce_pkg::COUNT_BITS)) ovf = 1;
    else begin
      n_items++;
      if (!skip) begin
        w_total += 33'(w);
        sx  += 49'($signed(w) * xs);
        sy  += 49'($signed(w) * ys);
        sxx += w * 64'(xs * xs);
        syy += w * 64'(ys * ys);
        sxy += $signed(w) * (xs * ys);
      end
    end
    if (last) begin
      st = coefficient(corr);
      exp_corr = {exp_corr, corr};
      exp_stat = {exp_stat, st};
      clear();
    end
  endfunction

  function void check_result(input logic [31:0] corr, input logic [1:0] st);
    logic [31:0] ec;
    logic [1:0]  es;
    results++;
    if (exp_corr.size() == 0) begin
      $display("%0t: unexpected result corr=%h status=%0d", $time, corr, st);
      errors++;
      return;
    end
    ec = exp_corr.pop_front();
    es = exp_stat.pop_front();
    if (st !== es) begin
      $display("%0t: status expected %0d actual %0d", $time, es, st);
      errors++;
    end
    if (corr !== ec) begin
      $display("%0t: correlation expected %h actual %h", $time, ec, corr);
      errors++;
    end
  endfunction
endclass

module pearson_correlation_engine_tb;

  localparam int WATCHDOG = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic        cfg_wr_data = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  corr_scoreboard sb;
  bit  calm;       // no idling in the last part
  int  idle_count;
  int  words_sent;

  pearson_correlation_engine dut (.*);

  always #2 clk = ~clk;

  // result side: random stall bursts
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 11);
        m_axis_tready <= 0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] w, input bit skip, input bit last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {w, y, x};
    s_axis_tuser  <= skip;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(x, y, w, skip, last);
    words_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.exp_corr.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_mode(input bit m);
    drain();
    cfg_wr_en   <= 1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.weighted = m;
  endtask

  task automatic random_series(input int len);
    logic [15:0] x, y, w, base;
    bit skip;
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0: x = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        1: x = base;  // constant series gives zero variance
        default: x = 16'($urandom);
      endcase
      y = ($urandom_range(0, 3) == 0) ? x ^ 16'($urandom_range(0, 7)) : 16'($urandom);
      w = ($urandom_range(0, 6) == 0) ? ($urandom_range(0, 1) ? 16'hffff : 16'h0)
                                      : 16'($urandom);
      skip = $urandom_range(0, 7) == 0;
      send_word(x, y, w, skip, i == len - 1);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    sb.weighted = 0;
    words_sent = 0;
    calm = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, perfect (anti)correlation, constant, skips, empty
    send_word(16'h7fff, 16'h7fff, 16'hffff, 1'b0, 1'b0);
    send_word(16'h8000, 16'h8000, 16'h0000, 1'b0, 1'b0);
    send_word(16'h0001, 16'h0001, 16'h0001, 1'b0, 1'b1);
    send_word(16'h7fff, 16'h8000, 16'h1234, 1'b0, 1'b0);
    send_word(16'h8000, 16'h7fff, 16'h0, 1'b0, 1'b1);
    send_word(16'h0005, 16'h0003, 16'h1, 1'b0, 1'b0);
    send_word(16'h0005, 16'hfffd, 16'h1, 1'b0, 1'b1);      // constant x
    send_word(16'h1111, 16'h2222, 16'h1, 1'b1, 1'b1);      // only a skipped word
    send_word(16'h0010, 16'h0001, 16'h1, 1'b0, 1'b0);
    send_word(16'hffff, 16'h0002, 16'h1, 1'b1, 1'b0);
    send_word(16'h0020, 16'h0009, 16'h1, 1'b0, 1'b1);
    set_mode(1'b1);
    send_word(16'h0003, 16'h0004, 16'h0, 1'b0, 1'b0);
    send_word(16'h0007, 16'h0001, 16'h0, 1'b0, 1'b1);      // zero weight sum
    send_word(16'h7fff, 16'h8000, 16'hffff, 1'b0, 1'b0);
    send_word(16'h8000, 16'h7fff, 16'h0001, 1'b0, 1'b0);
    send_word(16'h0100, 16'h0100, 16'h8000, 1'b1, 1'b1);
    // mode change mid-series
    send_word(16'h0040, 16'hffc0, 16'h0009, 1'b0, 1'b0);
    set_mode(1'b0);
    send_word(16'h0002, 16'h0003, 16'h0009, 1'b0, 1'b0);
    send_word(16'hff00, 16'h0077, 16'h0003, 1'b0, 1'b1);

    // random phases over both modes
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0]);
      while (words_sent < (ph + 1) * 190)
        random_series($urandom_range(1, 12));
    end

    calm = 1;
    set_mode(1'b1);
    while (words_sent < 1200) random_series($urandom_range(1, 10));
    drain();

    $display("Covered %0d words and %0d results over both modes,", words_sent, sb.results);
    $display("including edge samples, skips, zero variance and a mid-series mode change.");
    if (sb.errors == 0 && sb.exp_corr.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
